/* hw/rtl/xs1024_pkg.sv */
// xs1024_pkg: shared types, command codes and constants for the
// xorshift1024* generator. No dependencies.

package xs1024_pkg;

    localparam int WORD_COUNT = 16;
    localparam int POS_W      = 4;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;

    localparam logic [WORD_W-1:0] MUL_DRAW = 64'd1181783497276652981;
    localparam logic [WORD_W-1:0] MUL_SEED = 64'd2685821657736338717;

    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_RESEED = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic REG_SEED = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_FLUSH,
        ST_ALIGN
    } t_state;

    // work item traveling with a product through the multiplier
    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_DRAW,
        TOK_FILL,
        TOK_ZERO
    } t_tok;

    typedef struct packed {
        logic shift;
        logic wr;
    } t_cell_ctl;

    function automatic logic [WORD_W-1:0] seed_step(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] v;
        v = x ^ (x >> 12);
        v = v ^ (v << 25);
        v = v ^ (v >> 27);
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] draw_mix(input logic [WORD_W-1:0] s0,
                                                   input logic [WORD_W-1:0] s1);
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] u;
        t = s1 ^ (s1 << 31);
        t = t ^ (t >> 11);
        u = s0 ^ (s0 >> 30);
        return u ^ t;
    endfunction

endpackage

/* hw/rtl/xorshift1024star_generator_top.sv */
// xorshift1024star_generator_top: ring of sixteen state cells, command
// sequencer, shared multiplier and APB seed register.
// Depends on xs1024_pkg, xs1024_cell and xs1024_mul.
//
// Usage: a command transaction is taken when start is high and busy low.
// command 0 draws, 1 reseeds from the seed register, 2 loads one state word,
// 3 does nothing. Every command yields exactly one result, shown for one
// cycle with o_strobe; o_is_draw marks drawn values, other results carry 0.
// The seed register (64 bits) is written over APB at address 0.
// Results leave in command order through the two-stage multiplier and output register.
// Draws and no-ops keep busy low, so they can be issued every cycle.
// A reseed holds busy through sixteen xorshift64* steps into the
// multiplier, one per cycle, and a flush, while the ring shifts the products in.
// A load holds busy while the ring rotates one cell per cycle
// until the position is back at zero, then the word is written.
// Reset clears all state words, the position and the seed register.
// Results cannot be held off by the receiver; nothing waits on it.

module xorshift1024star_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_word_index,
    input  logic [63:0] i_load_word,
    output logic        o_strobe,
    output logic [63:0] o_random_value,
    output logic        o_is_draw,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int NW = xs1024_pkg::WORD_COUNT;
    localparam int PW = xs1024_pkg::POS_W;
    localparam int WW = xs1024_pkg::WORD_W;

    xs1024_pkg::t_state r_state;
    xs1024_pkg::t_state n_state;
    logic [PW-1:0]      r_pos;
    logic [PW-1:0]      n_pos;
    logic [PW-1:0]      r_cnt;
    logic [PW-1:0]      n_cnt;
    logic [WW-1:0]      r_x;
    logic [WW-1:0]      n_x;
    logic [WW-1:0]      r_seed;
    logic [PW-1:0]      r_ld_idx;
    logic [PW-1:0]      n_ld_idx;
    logic [WW-1:0]      r_ld_word;
    logic [WW-1:0]      n_ld_word;
    logic               r_strobe;
    logic               r_is_draw;
    logic [WW-1:0]      r_random_value;

    logic               accept;
    logic               cfg_wr;
    logic [WW-1:0]      mix;
    logic [WW-1:0]      x_next;
    xs1024_pkg::t_tok   mul_tok;
    logic [WW-1:0]      mul_opnd;
    xs1024_pkg::t_tok   out_tok;
    logic [WW-1:0]      out_prod;
    logic               do_draw;
    logic               do_rot;
    logic               do_fill;
    logic               wr_en;

    logic [WW-1:0]          word [NW];
    logic [WW-1:0]          nxt  [NW];
    xs1024_pkg::t_cell_ctl  ctl  [NW];

    assign busy   = (r_state != xs1024_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign mix    = xs1024_pkg::draw_mix(word[0], word[1]);
    assign x_next = xs1024_pkg::seed_step(r_x);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == xs1024_pkg::REG_SEED);
    assign prdata = (paddr[3] == xs1024_pkg::REG_SEED) ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (cfg_wr) begin
            r_seed <= pwdata;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_x       = r_x;
        n_ld_idx  = r_ld_idx;
        n_ld_word = r_ld_word;
        mul_tok   = xs1024_pkg::TOK_NONE;
        mul_opnd  = '0;
        do_draw   = 1'b0;
        do_rot    = 1'b0;
        wr_en     = 1'b0;
        unique case (r_state)
            xs1024_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        xs1024_pkg::CMD_DRAW: begin
                            mul_tok  = xs1024_pkg::TOK_DRAW;
                            mul_opnd = mix;
                            do_draw  = 1'b1;
                            n_pos    = r_pos + 1'b1;
                        end
                        xs1024_pkg::CMD_RESEED: begin
                            n_x     = r_seed;
                            n_cnt   = '0;
                            n_pos   = '0;
                            n_state = xs1024_pkg::ST_SEED;
                        end
                        xs1024_pkg::CMD_LOAD: begin
                            n_ld_idx  = i_word_index;
                            n_ld_word = i_load_word;
                            n_state   = xs1024_pkg::ST_ALIGN;
                        end
                        default: begin
                            mul_tok = xs1024_pkg::TOK_ZERO;
                        end
                    endcase
                end
            end
            xs1024_pkg::ST_SEED: begin
                n_x      = x_next;
                mul_tok  = xs1024_pkg::TOK_FILL;
                mul_opnd = x_next;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == PW'(NW - 1)) begin
                    n_state = xs1024_pkg::ST_FLUSH;
                end
            end
            xs1024_pkg::ST_FLUSH: begin
                // flush: waits while the last fill product lands in the ring
                if (r_cnt == '0) begin
                    mul_tok = xs1024_pkg::TOK_ZERO;
                    n_cnt   = r_cnt + 1'b1;
                end else begin
                    n_state = xs1024_pkg::ST_IDLE;
                end
            end
            xs1024_pkg::ST_ALIGN: begin
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    mul_tok = xs1024_pkg::TOK_ZERO;
                    n_state = xs1024_pkg::ST_IDLE;
                end else begin
                    do_rot = 1'b1;
                    n_pos  = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = xs1024_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xs1024_pkg::ST_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_ld_idx  <= n_ld_idx;
        r_ld_word <= n_ld_word;
    end

    xs1024_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tok     (mul_tok),
        .i_operand (mul_opnd),
        .o_tok     (out_tok),
        .o_product (out_prod)
    );

    assign do_fill = (out_tok == xs1024_pkg::TOK_FILL);

    // ring of cells: cell k holds word (position + k)
    for (genvar k = 0; k < NW; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign nxt[k] = do_draw ? mix : word[k+1];
        end else if (k == NW - 1) begin : g_tail
            assign nxt[k] = do_fill ? out_prod : word[0];
        end else begin : g_mid
            assign nxt[k] = word[k+1];
        end
        assign ctl[k].shift = do_draw || do_rot || do_fill;
        assign ctl[k].wr    = wr_en && (r_ld_idx == PW'(k));

        xs1024_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl[k]),
            .i_next    (nxt[k]),
            .i_wr_data (r_ld_word),
            .o_word    (word[k])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe  <= 1'b0;
            r_is_draw <= 1'b0;
        end else begin
            r_strobe  <= (out_tok == xs1024_pkg::TOK_DRAW) || (out_tok == xs1024_pkg::TOK_ZERO);
            r_is_draw <= (out_tok == xs1024_pkg::TOK_DRAW);
        end
    end

    always_ff @(posedge i_clk) begin
        r_random_value <= (out_tok == xs1024_pkg::TOK_DRAW) ? out_prod : '0;
    end

    assign o_strobe       = r_strobe;
    assign o_is_draw      = r_is_draw;
    assign o_random_value = r_random_value;

`ifndef NO_ASSERTIONS
    a_reseed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == xs1024_pkg::CMD_RESEED)) |=> busy)
        else $error("reseed did not raise busy");

    a_fill_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_tok == xs1024_pkg::TOK_FILL) |-> busy)
        else $error("fill product landed while idle");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_is_draw) |-> (o_random_value == '0))
        else $error("non-draw result carries a value");

    a_draw_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_is_draw)
        else $error("draw flag without strobe");
`endif

endmodule

/* hw/rtl/xs1024_cell.sv */
// xs1024_cell: one 64-bit state word of the ring; shifts from its neighbor
// or takes a direct write. Depends on xs1024_pkg.

module xs1024_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  xs1024_pkg::t_cell_ctl         i_ctl,
    input  logic [xs1024_pkg::WORD_W-1:0] i_next,
    input  logic [xs1024_pkg::WORD_W-1:0] i_wr_data,
    output logic [xs1024_pkg::WORD_W-1:0] o_word
);

    logic [xs1024_pkg::WORD_W-1:0] r_word;
    logic [xs1024_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.wr) begin
            n_word = i_wr_data;
        end else if (i_ctl.shift) begin
            n_word = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

/* hw/rtl/xs1024_mul.sv */
// xs1024_mul: two-stage 64x64 mod 2^64 multiplier by one of two constants,
// built from 32-bit partial products. Depends on xs1024_pkg.

module xs1024_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  xs1024_pkg::t_tok              i_tok,
    input  logic [xs1024_pkg::WORD_W-1:0] i_operand,
    output xs1024_pkg::t_tok              o_tok,
    output logic [xs1024_pkg::WORD_W-1:0] o_product
);

    localparam int HW = xs1024_pkg::HALF_W;

    logic [xs1024_pkg::WORD_W-1:0] coef;
    logic [xs1024_pkg::WORD_W-1:0] p0;
    logic [HW-1:0]                 p1;
    logic [HW-1:0]                 p2;

    xs1024_pkg::t_tok              r_tok1;
    logic [xs1024_pkg::WORD_W-1:0] r_p0;
    logic [HW-1:0]                 r_p1;
    logic [HW-1:0]                 r_p2;
    xs1024_pkg::t_tok              r_tok2;
    logic [xs1024_pkg::WORD_W-1:0] r_prod;
    logic [HW-1:0]                 mid_sum;

    assign coef = (i_tok == xs1024_pkg::TOK_FILL) ? xs1024_pkg::MUL_SEED
                                                  : xs1024_pkg::MUL_DRAW;
    assign p0 = {{HW{1'b0}}, i_operand[HW-1:0]} * {{HW{1'b0}}, coef[HW-1:0]};
    assign p1 = i_operand[HW-1:0] * coef[2*HW-1:HW];
    assign p2 = i_operand[2*HW-1:HW] * coef[HW-1:0];
    assign mid_sum = r_p1 + r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1 <= xs1024_pkg::TOK_NONE;
            r_tok2 <= xs1024_pkg::TOK_NONE;
        end else begin
            r_tok1 <= i_tok;
            r_tok2 <= r_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0   <= p0;
        r_p1   <= p1;
        r_p2   <= p2;
        r_prod <= r_p0 + {mid_sum, {HW{1'b0}}};
    end

    assign o_tok     = r_tok2;
    assign o_product = r_prod;

endmodule

/* tb/xorshift1024star_generator_top_tb.sv */
// Self-checking testbench for xorshift1024star_generator_top: draw, reseed, load
// and no-op command transactions are checked against an in-bench generator model.
// Depends on xs1024_pkg and the generator RTL.

module xorshift1024star_generator_top_tb;
    import xs1024_pkg::*;

    typedef struct {
        logic [1:0]  command;
        logic [3:0]  index;
        logic [63:0] word;
    } gen_cmd_t;

    typedef struct {
        logic [63:0] value;
        logic        is_draw;
    } gen_result_t;

    localparam logic [3:0] SEED_ADDR = 4'(8 * int'(REG_SEED));
    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [63:0] TOP_BIT  = {1'b1, 63'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = CMD_NOP;
    logic [3:0]  i_word_index = '0;
    logic [63:0] i_load_word = '0;
    logic        o_strobe;
    logic [63:0] o_random_value;
    logic        o_is_draw;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // generator model state
    logic [63:0] gen_words [WORD_COUNT];
    logic [3:0]  gen_pos;
    logic [63:0] seed_reg;

    gen_cmd_t    cmd_backlog[$];
    gen_result_t expected_values[$];
    gen_cmd_t    cur_cmd;
    logic        gaps_on = 1'b1;
    int          fail_count = 0;

    xorshift1024star_generator_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_word_index   (i_word_index),
        .i_load_word    (i_load_word),
        .o_strobe       (o_strobe),
        .o_random_value (o_random_value),
        .o_is_draw      (o_is_draw),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 400000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void step_generator(gen_cmd_t c);
        gen_result_t r;
        logic [63:0] s0;
        logic [63:0] s1;
        logic [63:0] x;
        r.value   = '0;
        r.is_draw = 1'b0;
        case (c.command)
            CMD_DRAW: begin
                s0 = gen_words[gen_pos];
                gen_pos = gen_pos + 4'd1;
                s1 = gen_words[gen_pos];
                s1 = s1 ^ (s1 << 31);
                s1 = s1 ^ (s1 >> 11);
                s0 = s0 ^ (s0 >> 30);
                gen_words[gen_pos] = s0 ^ s1;
                r.value   = gen_words[gen_pos] * MUL_DRAW;
                r.is_draw = 1'b1;
            end
            CMD_RESEED: begin
                x = seed_reg;
                for (int i = 0; i < WORD_COUNT; i++) begin
                    x = x ^ (x >> 12);
                    x = x ^ (x << 25);
                    x = x ^ (x >> 27);
                    gen_words[i] = x * MUL_SEED;
                end
                gen_pos = '0;
            end
            CMD_LOAD: begin
                gen_words[c.index] = c.word;
                gen_pos = '0;
            end
            default: ;
        endcase
        expected_values.push_back(r);
    endfunction

    function automatic void queue_cmd(logic [1:0] command, logic [3:0] index,
                                      logic [63:0] word);
        gen_cmd_t c;
        c.command = command;
        c.index   = index;
        c.word    = word;
        cmd_backlog.push_back(c);
    endfunction

    function automatic void queue_random_cmd();
        int          pick;
        logic [1:0]  command;
        logic [63:0] word;
        pick = $urandom_range(99);
        if (pick < 72) begin
            command = CMD_DRAW;
        end else if (pick < 82) begin
            command = CMD_LOAD;
        end else if (pick < 88) begin
            command = CMD_RESEED;
        end else begin
            command = CMD_NOP;
        end
        case ($urandom_range(15))
            0: word = '0;
            1: word = ALL_ONES;
            default: word = {$urandom, $urandom};
        endcase
        queue_cmd(command, 4'($urandom_range(15)), word);
    endfunction

    task automatic write_seed(input logic [63:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        seed_reg = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || start || expected_values.size() != 0 || busy)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // command driver
    always @(posedge i_clk) begin
        logic launch;
        launch = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                step_generator(cur_cmd);
            end
            if (!start || !busy) begin
                if (cmd_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 21)) begin
                    cur_cmd = cmd_backlog.pop_front();
                    launch  = 1'b1;
                    i_command    <= cur_cmd.command;
                    i_word_index <= cur_cmd.index;
                    i_load_word  <= cur_cmd.word;
                end
                start <= launch;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        gen_result_t want;
        if (i_rst_n && o_strobe) begin
            if (expected_values.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected transaction: random_value=%h is_draw=%b",
                             o_random_value, o_is_draw);
            end else begin
                want = expected_values.pop_front();
                if (o_random_value !== want.value || o_is_draw !== want.is_draw) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: random_value exp %h got %h, is_draw exp %b got %b",
                                 want.value, o_random_value, want.is_draw, o_is_draw);
                end
            end
        end
    end

    initial begin
        logic [63:0] phase_seed [8];
        foreach (gen_words[i]) gen_words[i] = '0;
        gen_pos  = '0;
        seed_reg = '0;
        phase_seed = '{64'd0, ALL_ONES, 64'd0, 64'd1, 64'd0, 64'd0, 64'd0, TOP_BIT};
        phase_seed[0] = {$urandom, $urandom};
        phase_seed[2] = {$urandom, $urandom};
        phase_seed[4] = {$urandom, $urandom};
        phase_seed[6] = {$urandom, $urandom};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero state after reset, no-op, zero seed, loads at the index and word extremes
        write_seed(64'd0);
        queue_cmd(CMD_DRAW, 4'd0, 64'd0);
        queue_cmd(CMD_DRAW, 4'd15, ALL_ONES);
        queue_cmd(CMD_NOP, 4'd15, ALL_ONES);
        queue_cmd(CMD_RESEED, 4'd0, 64'd0);
        queue_cmd(CMD_DRAW, 4'd0, 64'd0);
        queue_cmd(CMD_LOAD, 4'd15, ALL_ONES);
        queue_cmd(CMD_LOAD, 4'd0, 64'd0);
        queue_cmd(CMD_LOAD, 4'd1, 64'd1);
        queue_cmd(CMD_DRAW, 4'd0, 64'd0);
        queue_cmd(CMD_DRAW, 4'd0, 64'd0);
        queue_cmd(CMD_LOAD, 4'd0, TOP_BIT);
        queue_cmd(CMD_DRAW, 4'd0, 64'd0);
        wait_idle();
        write_seed(ALL_ONES);
        queue_cmd(CMD_RESEED, 4'd0, 64'd0);
        repeat (4) queue_cmd(CMD_DRAW, 4'd0, 64'd0);
        queue_cmd(CMD_NOP, 4'd0, 64'd0);
        wait_idle();
        write_seed(64'd1);
        queue_cmd(CMD_RESEED, 4'd0, 64'd0);
        repeat (3) queue_cmd(CMD_DRAW, 4'd0, 64'd0);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            write_seed(phase_seed[p]);
            gaps_on = (p != 2);
            queue_cmd(CMD_RESEED, 4'($urandom_range(15)), {$urandom, $urandom});
            repeat (155) queue_random_cmd();
            wait_idle();
        end

        if (fail_count == 0 && expected_values.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
